### hdl/tcrp_pkg.sv
// Shared types and constants of the TS continuity checker and RTP packetizer.
package tcrp_pkg;

    localparam int PID_W         = 13;
    localparam int CC_W          = 4;
    localparam int FILL_W        = 11;
    localparam int SEQ_W         = 16;
    localparam int CNT_W         = 32;
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;

    localparam logic [7:0] SYNC_BYTE = 8'h47;
    localparam logic [7:0] MIN_BYTES = 8'd3;

    localparam int MTU_BYTES  = 1500;
    localparam int TS_LEN     = 188;
    localparam int HEADER_LEN = 12;

    localparam logic [FILL_W-1:0] FILL_MAX    = {FILL_W{1'b1}};
    localparam logic [FILL_W-1:0] FLUSH_LIMIT = FILL_W'(MTU_BYTES - HEADER_LEN - TS_LEN);
    localparam logic [CNT_W-1:0]  DEADLINE_STEP = 32'd100;
    localparam logic [CNT_W-1:0]  RTP_CLOCK_MULT = 32'd90;

    localparam logic REG_SYNC_SOURCE_ID = 1'b0;

    typedef struct packed {
        logic              unseen;
        logic [CC_W-1:0]   cc;
        logic [CNT_W-1:0]  packets;
        logic [CNT_W-1:0]  errors;
    } pid_entry_t;

    localparam pid_entry_t PID_ENTRY_RESET = '{
        unseen:  1'b1,
        cc:      '0,
        packets: '0,
        errors:  '0
    };

    typedef struct packed {
        logic              en;
        logic [PID_W-1:0]  addr;
    } pid_rd_t;

    typedef struct packed {
        logic              en;
        logic [PID_W-1:0]  addr;
        pid_entry_t        data;
    } pid_wr_t;

endpackage

### hdl/tcrp_pid_mem.sv
// Per-PID state memory with clearing sweep and last-write forwarding.
module tcrp_pid_mem #(
    parameter int PID_COUNT = 8192
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  tcrp_pkg::pid_rd_t   rd,
    input  tcrp_pkg::pid_wr_t   wr,
    output tcrp_pkg::pid_entry_t rd_entry,
    output logic                clear_busy
);
    import tcrp_pkg::*;

    localparam int AW = (PID_COUNT > 1) ? $clog2(PID_COUNT) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(PID_COUNT - 1);

    pid_entry_t mem [PID_COUNT];

    logic            clear_busy_reg;
    logic [AW-1:0]   clr_addr_reg;
    pid_entry_t      rd_data_reg;
    pid_entry_t      last_wr_reg;
    logic            fwd_reg;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    pid_entry_t      mem_wdata;
    logic [AW-1:0]   mem_raddr;

    assign clear_busy = clear_busy_reg;
    assign mem_raddr  = rd.addr[AW-1:0];

    always_comb begin
        if (clear_busy_reg) begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = PID_ENTRY_RESET;
        end else begin
            mem_we    = wr.en;
            mem_waddr = wr.addr[AW-1:0];
            mem_wdata = wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd.en) begin
            rd_data_reg <= mem[mem_raddr];
        end
        if (mem_we) begin
            last_wr_reg <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_busy_reg <= 1'b1;
            clr_addr_reg   <= '0;
            fwd_reg        <= 1'b0;
        end else begin
            if (clear_busy_reg) begin
                if (clr_addr_reg == LAST_ADDR) begin
                    clear_busy_reg <= 1'b0;
                end else begin
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                end
            end
            if (rd.en) begin
                fwd_reg <= mem_we && (mem_waddr == mem_raddr);
            end
        end
    end

    assign rd_entry = fwd_reg ? last_wr_reg : rd_data_reg;

endmodule

### hdl/ts_continuity_rtp_packetizer_unit.sv
// Top level: TS continuity checker with RTP MP2T payload fill accounting.
// Takes one TS packet header per cycle, sustained while m_ready is high and the
// clearing pass is done. An accepted transfer is in the update stage the next
// cycle; its result enters the output register when the update stage advances.
// The rate is set by the per-PID read-modify-write: the entry is read from a
// synchronous memory when the transfer is accepted and written back when the
// update stage hands its result on; a back-to-back transfer on the same PID
// takes the forwarded write. After reset a clearing pass writes every per-PID
// entry, one a cycle, while s_ready stays low; APB writes are taken throughout.
module ts_continuity_rtp_packetizer_unit #(
    parameter int PID_COUNT = 8192
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tcrp_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [tcrp_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [tcrp_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [7:0]                         s_header_byte0,
    input  logic [7:0]                         s_header_byte1,
    input  logic [7:0]                         s_header_byte2,
    input  logic [7:0]                         s_header_byte3,
    input  logic [7:0]                         s_packet_bytes,
    input  logic [31:0]                        s_now_ms,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [12:0]                        m_pid_value,
    output logic                               m_header_checked,
    output logic [3:0]                         m_continuity_gap,
    output logic [31:0]                        m_pid_packet_total,
    output logic [31:0]                        m_pid_error_total,
    output logic                               m_flush_now,
    output logic [15:0]                        m_rtp_sequence,
    output logic [31:0]                        m_rtp_timestamp,
    output logic [10:0]                        m_payload_length,
    output logic [31:0]                        m_sent_packet_total,
    output logic [31:0]                        m_sent_octet_total
);
    import tcrp_pkg::*;

    // configuration
    logic [15:0] sync_source_id_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_source_id_reg <= '0;
        end else if (psel && penable && pwrite && (paddr[2] == REG_SYNC_SOURCE_ID)) begin
            sync_source_id_reg <= pwdata[15:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_SYNC_SOURCE_ID) begin
            prdata = {16'b0, sync_source_id_reg};
        end
    end

    // per-PID store
    pid_rd_t    pid_rd;
    pid_wr_t    pid_wr;
    pid_entry_t cur_entry;
    logic       clear_busy;

    tcrp_pid_mem #(
        .PID_COUNT(PID_COUNT)
    ) u_pid_mem (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rd         (pid_rd),
        .wr         (pid_wr),
        .rd_entry   (cur_entry),
        .clear_busy (clear_busy)
    );

    // update stage
    logic        s1_valid_reg;
    logic [7:0]  s1_b0_reg;
    logic [7:0]  s1_b1_reg;
    logic [7:0]  s1_b2_reg;
    logic [7:0]  s1_b3_reg;
    logic [7:0]  s1_bytes_reg;
    logic [31:0] s1_now_reg;

    logic s1_adv;
    logic s_xfer;

    assign s1_adv  = s1_valid_reg && (!m_valid || m_ready);
    assign s_ready = !clear_busy && (!s1_valid_reg || s1_adv);
    assign s_xfer  = s_valid && s_ready;

    assign pid_rd.en   = s_xfer;
    assign pid_rd.addr = {s_header_byte1[4:0], s_header_byte2};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            s1_b0_reg    <= s_header_byte0;
            s1_b1_reg    <= s_header_byte1;
            s1_b2_reg    <= s_header_byte2;
            s1_b3_reg    <= s_header_byte3;
            s1_bytes_reg <= s_packet_bytes;
            s1_now_reg   <= s_now_ms;
        end
    end

    // session state
    logic [FILL_W-1:0] fill_reg;
    logic [SEQ_W-1:0]  seq_reg;
    logic [31:0]       deadline_reg;
    logic [31:0]       packets_sent_reg;
    logic [31:0]       octets_sent_reg;

    logic              active;
    logic              checked;
    logic              in_range;
    logic [PID_W-1:0]  pid;
    logic [CC_W-1:0]   cc;
    logic [CC_W-1:0]   gap;
    pid_entry_t        new_entry;
    logic [FILL_W:0]   fill_sum;
    logic [FILL_W-1:0] fill_new;
    logic              flush;
    logic [SEQ_W-1:0]  seq_new;
    logic [31:0]       packets_new;
    logic [31:0]       octets_new;

    always_comb begin
        active   = (s1_bytes_reg != 8'd0);
        checked  = active && (s1_b0_reg == SYNC_BYTE) && (s1_bytes_reg > MIN_BYTES);
        pid      = {s1_b1_reg[4:0], s1_b2_reg};
        in_range = checked && ({1'b0, pid} < (PID_W + 1)'(PID_COUNT));
        cc       = s1_b3_reg[CC_W-1:0];

        gap = cur_entry.unseen ? '0 : (cc - (cur_entry.cc + CC_W'(1)));
        new_entry.unseen  = 1'b0;
        new_entry.cc      = cc;
        new_entry.packets = cur_entry.packets + 32'd1;
        new_entry.errors  = cur_entry.errors + {28'b0, gap};

        fill_sum = {1'b0, fill_reg} + (FILL_W + 1)'(s1_bytes_reg);
        fill_new = fill_sum[FILL_W] ? FILL_MAX : fill_sum[FILL_W-1:0];
        flush    = active && ((fill_new > FLUSH_LIMIT) || (deadline_reg < s1_now_reg));

        seq_new     = seq_reg + SEQ_W'(1);
        packets_new = packets_sent_reg + 32'd1;
        octets_new  = octets_sent_reg + {21'b0, fill_new};
    end

    assign pid_wr.en   = s1_adv && in_range;
    assign pid_wr.addr = pid;
    assign pid_wr.data = new_entry;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg         <= '0;
            seq_reg          <= '0;
            deadline_reg     <= '0;
            packets_sent_reg <= '0;
            octets_sent_reg  <= '0;
        end else if (s1_adv && active) begin
            if (flush) begin
                fill_reg         <= '0;
                seq_reg          <= seq_new;
                deadline_reg     <= s1_now_reg + DEADLINE_STEP;
                packets_sent_reg <= packets_new;
                octets_sent_reg  <= octets_new;
            end else begin
                fill_reg <= fill_new;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (s1_adv) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_pid_value        <= checked ? pid : '0;
            m_header_checked   <= checked;
            m_continuity_gap   <= in_range ? gap : '0;
            m_pid_packet_total <= in_range ? new_entry.packets : '0;
            m_pid_error_total  <= in_range ? new_entry.errors : '0;
            m_flush_now        <= flush;
            m_rtp_sequence     <= flush ? seq_new : '0;
            m_rtp_timestamp    <= flush ? 32'(s1_now_reg * RTP_CLOCK_MULT) : '0;
            m_payload_length   <= flush ? fill_new : '0;
            m_sent_packet_total <= flush ? packets_new : packets_sent_reg;
            m_sent_octet_total  <= flush ? octets_new : octets_sent_reg;
        end
    end

endmodule
